/* rtl/core/right_diagonal_sum_matrix_macros.svh */
// Assertion helpers used by the datapath module.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef RIGHT_DIAGONAL_SUM_MATRIX_MACROS_SVH
`define RIGHT_DIAGONAL_SUM_MATRIX_MACROS_SVH

// Same-cycle implication
`define RDSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define RDSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/rdsm_pkg.sv */
package rdsm_pkg;

    localparam int ELEM_W    = 16;
    localparam int SUM_W     = 20;
    localparam int IDX_W     = 3;
    localparam int SIZE_W    = 4;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 4;
    localparam int TDATA_W   = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 4'd1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CENTER,
        ST_DOWN,
        ST_UP,
        ST_EMIT
    } rdsm_state_t;

    typedef enum logic [1:0] {
        RD_CENTER,
        RD_DOWN,
        RD_UP
    } rdsm_rd_sel_t;

    typedef struct packed {
        logic         load_wr;
        logic         rd_en;
        rdsm_rd_sel_t rd_sel;
        logic         k_rst;
        logic         emit;
        logic         cell_next;
    } rdsm_cmd_t;

    typedef struct packed {
        logic load_final;
        logic down_ok;
        logic up_ok;
        logic cell_last;
        logic out_free;
    } rdsm_status_t;

endpackage

/* rtl/core/rdsm_datapath.sv */
`include "right_diagonal_sum_matrix_macros.svh"

module rdsm_datapath #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [rdsm_pkg::ELEM_W-1:0]       s_element,
    input  logic                              cfg_valid,
    input  logic [rdsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rdsm_pkg::SIZE_W-1:0]       cfg_data,
    input  rdsm_pkg::rdsm_cmd_t               cmd,
    output rdsm_pkg::rdsm_status_t            status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rdsm_pkg::TDATA_W-1:0]      m_tdata,
    output logic                              m_tlast
);
    import rdsm_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SIZE_W-1:0]        row_count_reg;
    logic [SIZE_W-1:0]        col_count_reg;
    logic [COUNT_W-1:0]       load_count_reg;
    logic [COUNT_W-1:0]       load_count_next;
    logic [IDX_W-1:0]         i_reg;
    logic [IDX_W-1:0]         j_reg;
    logic [SIZE_W-1:0]        k_reg;
    logic                     rvalid_reg;
    logic                     rfirst_reg;
    logic signed [ELEM_W-1:0] rdata_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic                     out_last_reg;

    logic signed [ELEM_W-1:0] mem [DEPTH];

    logic [SIZE_W-1:0]  rows;
    logic [SIZE_W-1:0]  cols;
    logic [7:0]         total;
    logic [7:0]         count_inc;
    logic [SIZE_W:0]    down_row;
    logic [SIZE_W:0]    diag_col;
    logic [SIZE_W-1:0]  rd_row;
    logic [SIZE_W-1:0]  rd_col;
    logic [7:0]         rd_addr_full;
    logic [AW-1:0]      rd_addr;
    logic               cfg_known;

    // Clamp the size registers into the legal range
    always_comb begin
        if (row_count_reg == '0) begin
            rows = SIZE_W'(1);
        end else if (row_count_reg > SIZE_W'(MAX_ROWS)) begin
            rows = SIZE_W'(MAX_ROWS);
        end else begin
            rows = row_count_reg;
        end
        if (col_count_reg == '0) begin
            cols = SIZE_W'(1);
        end else if (col_count_reg > SIZE_W'(MAX_COLS)) begin
            cols = SIZE_W'(MAX_COLS);
        end else begin
            cols = col_count_reg;
        end
    end

    assign total     = 8'(rows) * 8'(cols);
    assign count_inc = 8'(load_count_reg) + 8'd1;
    assign cfg_known = cfg_valid &&
                       (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT);

    // Walk position for the diagonals
    assign down_row = (SIZE_W+1)'(i_reg) + (SIZE_W+1)'(k_reg);
    assign diag_col = (SIZE_W+1)'(j_reg) + (SIZE_W+1)'(k_reg);

    always_comb begin
        case (cmd.rd_sel)
            RD_CENTER: begin
                rd_row = SIZE_W'(i_reg);
                rd_col = SIZE_W'(j_reg);
            end
            RD_DOWN: begin
                rd_row = down_row[SIZE_W-1:0];
                rd_col = diag_col[SIZE_W-1:0];
            end
            RD_UP: begin
                rd_row = SIZE_W'(i_reg) - k_reg;
                rd_col = diag_col[SIZE_W-1:0];
            end
            default: begin
                rd_row = '0;
                rd_col = '0;
            end
        endcase
    end

    assign rd_addr_full = 8'(rd_row) * 8'(cols) + 8'(rd_col);
    assign rd_addr      = rd_addr_full[AW-1:0];

    // Status back to the controller
    always_comb begin
        status.load_final = (count_inc >= total);
        status.down_ok    = (down_row < (SIZE_W+1)'(rows)) &&
                            (diag_col < (SIZE_W+1)'(cols));
        status.up_ok      = (k_reg <= SIZE_W'(i_reg)) &&
                            (diag_col < (SIZE_W+1)'(cols));
        status.cell_last  = (SIZE_W'(i_reg) == rows - SIZE_W'(1)) &&
                            (SIZE_W'(j_reg) == cols - SIZE_W'(1));
        status.out_free   = !out_valid_reg || m_tready;
    end

    // Load counter: restart on any known register write, wrap on final word
    always_comb begin
        load_count_next = load_count_reg;
        if (cfg_known) begin
            load_count_next = '0;
        end else if (cmd.load_wr) begin
            if (status.load_final) begin
                load_count_next = '0;
            end else begin
                load_count_next = count_inc[COUNT_W-1:0];
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= SIZE_W'(8);
            col_count_reg  <= SIZE_W'(8);
            load_count_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            rvalid_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == REG_ROW_COUNT) begin
                row_count_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_COL_COUNT) begin
                col_count_reg <= cfg_data;
            end
            load_count_reg <= load_count_next;
            rvalid_reg     <= cmd.rd_en;
            if (cmd.cell_next) begin
                if (SIZE_W'(j_reg) == cols - SIZE_W'(1)) begin
                    j_reg <= '0;
                    if (SIZE_W'(i_reg) == rows - SIZE_W'(1)) begin
                        i_reg <= '0;
                    end else begin
                        i_reg <= i_reg + IDX_W'(1);
                    end
                end else begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Diagonal step counter
    always_ff @(posedge aclk) begin
        if (cmd.k_rst) begin
            k_reg <= SIZE_W'(1);
        end else if (cmd.rd_en && cmd.rd_sel != RD_CENTER) begin
            k_reg <= k_reg + SIZE_W'(1);
        end
    end

    // Matrix store: one write port for loading, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.load_wr && load_count_reg < COUNT_W'(DEPTH)) begin
            mem[load_count_reg[AW-1:0]] <= s_element;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        rfirst_reg <= cmd.rd_en && cmd.rd_sel == RD_CENTER;
    end

    // Accumulate the walk; the center word restarts the sum
    always_ff @(posedge aclk) begin
        if (rvalid_reg) begin
            if (rfirst_reg) begin
                acc_reg <= SUM_W'(rdata_reg);
            end else begin
                acc_reg <= acc_reg + SUM_W'(rdata_reg);
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_sum_reg  <= acc_reg;
            out_last_reg <= status.cell_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - SUM_W - 2*IDX_W){1'b0}},
                       out_sum_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

    `RDSM_ASSERT_NOW(a_read_in_matrix, cmd.rd_en,
        (rd_row < rows) && (rd_col < cols), "read outside the matrix")
    `RDSM_ASSERT_NOW(a_emit_free, cmd.emit, status.out_free,
        "result overwrites a pending word")
    `RDSM_ASSERT_NEXT(a_load_idle_walk, cmd.load_wr, !rvalid_reg,
        "walk read in flight during load")

endmodule

/* rtl/core/rdsm_ctrl.sv */
module rdsm_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  rdsm_pkg::rdsm_status_t   status,
    output rdsm_pkg::rdsm_cmd_t      cmd
);
    import rdsm_pkg::*;

    rdsm_state_t state_reg;
    rdsm_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid && status.load_final) begin
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER: begin
                state_next = ST_DOWN;
            end
            ST_DOWN: begin
                if (!status.down_ok) begin
                    state_next = ST_UP;
                end
            end
            ST_UP: begin
                if (!status.up_ok) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = status.cell_last ? ST_LOAD : ST_CENTER;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_tready      = 1'b0;
        cmd.load_wr   = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_sel    = RD_CENTER;
        cmd.k_rst     = 1'b0;
        cmd.emit      = 1'b0;
        cmd.cell_next = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready    = 1'b1;
                cmd.load_wr = s_tvalid;
            end
            ST_CENTER: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CENTER;
                cmd.k_rst  = 1'b1;
            end
            ST_DOWN: begin
                cmd.rd_sel = RD_DOWN;
                cmd.rd_en  = status.down_ok;
                cmd.k_rst  = !status.down_ok;
            end
            ST_UP: begin
                cmd.rd_sel = RD_UP;
                cmd.rd_en  = status.up_ok;
            end
            ST_EMIT: begin
                cmd.emit      = status.out_free;
                cmd.cell_next = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/right_diagonal_sum_matrix.sv */
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_tvalid / s_tready  | s_tdata[15:0] element
// m_       | out       | m_tvalid / m_tready  | m_tdata row, col, diag_sum; m_tlast
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index register, cfg_data value
//
// Loading takes one word per cycle. After the final element each cell takes a
// center read, its d and u diagonal reads plus one end check each, and an emit,
// as every element goes through the single read port of the matrix store.
// Reset is synchronous; the store is not cleared, each load writes what it reads.
// A stalled m_ side holds the walk at the cell being emitted; s_tready is low
// until the last result is in the output register. cfg_ready stays high.
module right_diagonal_sum_matrix #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] element
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rdsm_pkg::TDATA_W-1:0]    m_tdata,   // [2:0] row, [5:3] col,
                                                       // [25:6] diag_sum, rest zero
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rdsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rdsm_pkg::SIZE_W-1:0]     cfg_data
);
    import rdsm_pkg::*;

    rdsm_cmd_t    cmd;
    rdsm_status_t status;

    assign cfg_ready = 1'b1;

    rdsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rdsm_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_element (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
